// ===== rtl/tcwt_pkg.sv =====
// Shared types, codes and helper functions for the TCP window tracker.
// No dependencies; every other file in rtl except tcwt_checker imports this package.
package tcwt_pkg;

    localparam int CONNECTIONS_DEF = 1024;
    localparam int IDX_W = 10;

    localparam logic [31:0] ACK_SLACK = 32'd67035;  // 0xffff + 1500

    // Opcodes.
    localparam logic [1:0] OP_CHECK  = 2'd0;
    localparam logic [1:0] OP_CREATE = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    // Verdicts.
    localparam logic [2:0] VD_INVALID  = 3'd0;
    localparam logic [2:0] VD_VALID    = 3'd1;
    localparam logic [2:0] VD_RESTART  = 3'd2;
    localparam logic [2:0] VD_REOPEN   = 3'd3;
    localparam logic [2:0] VD_ACCEPTED = 3'd4;

    // Peer phases.
    localparam logic [2:0] PH_CLOSED   = 3'd0;
    localparam logic [2:0] PH_SYN_SENT = 3'd1;
    localparam logic [2:0] PH_ESTAB    = 3'd2;
    localparam logic [2:0] PH_CLOSING  = 3'd3;
    localparam logic [2:0] PH_FINWAIT2 = 3'd4;
    localparam logic [2:0] PH_TIMEWAIT = 3'd5;

    // Flag bit positions.
    localparam int FB_FIN = 0;
    localparam int FB_SYN = 1;
    localparam int FB_RST = 2;
    localparam int FB_PSH = 3;
    localparam int FB_ACK = 4;
    localparam int FB_URG = 5;

    // Option mark bits.
    localparam int OB_WS   = 0;
    localparam int OB_SACK = 1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SYN_SENT = 3'd0;
    localparam logic [2:0] CFG_SYN_RECV = 3'd1;
    localparam logic [2:0] CFG_ESTAB    = 3'd2;
    localparam logic [2:0] CFG_FIN_WAIT = 3'd3;
    localparam logic [2:0] CFG_CLOSE    = 3'd4;
    localparam logic [2:0] CFG_MAX_WS   = 3'd5;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } tcwt_state_t;

    typedef struct packed {
        logic [31:0] seq_cur;
        logic [31:0] seq_lim;
        logic [15:0] max_win;
        logic [3:0]  wshift;
        logic [1:0]  marks;
        logic [2:0]  phase;
    } tcwt_peer_t;

    typedef struct packed {
        tcwt_peer_t p1;
        tcwt_peer_t p0;
    } tcwt_row_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        direction;
        logic [7:0]  seg_flags;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [15:0] window;
        logic [15:0] payload_len;
        logic        wscale_present;
        logic [7:0]  wscale_value;
        logic        sack_present;
        logic [31:0] now_time;
    } tcwt_item_t;

    typedef struct packed {
        logic [31:0] to_syn_sent;
        logic [31:0] to_syn_recv;
        logic [31:0] to_estab;
        logic [31:0] to_fin_wait;
        logic [31:0] to_close;
        logic [3:0]  max_ws;
    } tcwt_cfg_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        refresh;
        logic [31:0] expiry;
    } tcwt_result_t;

    function automatic logic seq_geq(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        begin
            d = a - b;
            return ~d[31];
        end
    endfunction

    function automatic logic [15:0] ceil_shift(input logic [15:0] v, input logic [3:0] s);
        logic [31:0] t;
        begin
            t = ({16'd0, v} + (32'd1 << s) - 32'd1) >> s;
            return t[15:0];
        end
    endfunction

    function automatic logic flags_bad(input logic [7:0] f);
        logic bad;
        begin
            bad = 1'b0;
            if (f[FB_SYN])
            begin
                if (f[FB_RST] | f[FB_FIN])
                    bad = 1'b1;
            end
            else if (!(f[FB_ACK] | f[FB_RST]))
                bad = 1'b1;
            if (!f[FB_ACK] && (f[FB_FIN] | f[FB_PSH] | f[FB_URG]))
                bad = 1'b1;
            return bad;
        end
    endfunction

endpackage

// ===== rtl/tcp_conntrack_window_tracker.sv =====
// TCP connection tracker with sequence-window checking, top level.
// Depends on tcwt_pkg, tcwt_table and tcwt_engine.
//
// Usage:
//   s_* channel carries one parsed segment per transaction: the opcode in
//   s_tuser, the rest of the segment in s_tdata. m_* channel returns exactly
//   one result per segment: verdict in m_tuser, refresh flag and new
//   deadline in m_tdata. cfg_* writes the timeout and window scale
//   registers; write only while no segment is in flight.
// Timing:
//   The accept cycle (ST_IDLE) issues the table read, then ST_EXEC
//   evaluates the row, writes it back and loads the output register; the
//   connection table memory has a registered read. m_tvalid rises once
//   the output register has been loaded. A new segment is taken as soon
//   as the previous one has been written back.
// Stalls:
//   A pending result waits in the output register; the next segment is
//   still accepted and held in evaluation until the output is free.
// Reset:
//   rst_n clears control state and loads the register defaults. The table
//   needs no clearing pass: a row is defined once a create writes it.
module tcp_conntrack_window_tracker
    import tcwt_pkg::*;
#(
    parameter int CONNECTIONS = CONNECTIONS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // conn_index[9:0] direction[10] seg_flags[18:11] seq_number[50:19]
    // ack_number[82:51] window[98:83] payload_len[114:99] wscale_present[115]
    // wscale_value[123:116] sack_present[124] now_time[156:125], zero above
    input  logic [159:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // timer_refresh[0] expiry_time[32:1], zero above
    output logic [39:0]  m_tdata,
    // verdict[2:0]
    output logic [2:0]   m_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int AW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;

    tcwt_state_t  state_reg;
    tcwt_state_t  state_next;
    tcwt_item_t   item_reg;
    tcwt_cfg_t    cfg_reg;
    logic [AW-1:0] addr_reg;
    logic         out_valid_reg;
    tcwt_result_t out_reg;

    logic         in_take;
    logic         exec_done;
    logic [AW-1:0] in_addr;
    tcwt_row_t    row_rd;
    tcwt_row_t    row_wr;
    tcwt_result_t eng_result;
    tcwt_item_t   in_item;

    // Fold the slot index into the table range.
    function automatic logic [AW-1:0] fold_index(input logic [IDX_W-1:0] idx);
        logic [31:0] r;
        logic [31:0] m;
        begin
            r = {{(32-IDX_W){1'b0}}, idx};
            for (int k = IDX_W - 1; k >= 0; k--)
            begin
                m = 32'(CONNECTIONS) << k;
                if (r >= m)
                    r = r - m;
            end
            return r[AW-1:0];
        end
    endfunction

    always_comb
    begin
        in_item.opcode         = s_tuser;
        in_item.direction      = s_tdata[10];
        in_item.seg_flags      = s_tdata[18:11];
        in_item.seq_number     = s_tdata[50:19];
        in_item.ack_number     = s_tdata[82:51];
        in_item.window         = s_tdata[98:83];
        in_item.payload_len    = s_tdata[114:99];
        in_item.wscale_present = s_tdata[115];
        in_item.wscale_value   = s_tdata[123:116];
        in_item.sack_present   = s_tdata[124];
        in_item.now_time       = s_tdata[156:125];
    end

    assign in_addr   = fold_index(s_tdata[IDX_W-1:0]);
    assign in_take   = s_tvalid && s_tready;
    assign exec_done = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            default:  s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_done)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold the segment being evaluated and the result waiting to leave.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_item;
            addr_reg <= in_addr;
        end
        if (exec_done)
            out_reg <= eng_result;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.to_syn_sent <= 32'd120;
            cfg_reg.to_syn_recv <= 32'd60;
            cfg_reg.to_estab    <= 32'd86400;
            cfg_reg.to_fin_wait <= 32'd120;
            cfg_reg.to_close    <= 32'd10;
            cfg_reg.max_ws      <= 4'd14;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYN_SENT: cfg_reg.to_syn_sent <= cfg_data;
                CFG_SYN_RECV: cfg_reg.to_syn_recv <= cfg_data;
                CFG_ESTAB:    cfg_reg.to_estab    <= cfg_data;
                CFG_FIN_WAIT: cfg_reg.to_fin_wait <= cfg_data;
                CFG_CLOSE:    cfg_reg.to_close    <= cfg_data;
                CFG_MAX_WS:   cfg_reg.max_ws      <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    tcwt_table #(
        .DEPTH (CONNECTIONS),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .rd_en   (in_take),
        .rd_addr (in_addr),
        .rd_data (row_rd),
        .wr_en   (exec_done),
        .wr_addr (addr_reg),
        .wr_data (row_wr)
    );

    tcwt_engine u_engine (
        .item    (item_reg),
        .row_in  (row_rd),
        .cfg     (cfg_reg),
        .row_out (row_wr),
        .result  (eng_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.verdict;
    assign m_tdata  = {7'd0, out_reg.expiry, out_reg.refresh};

endmodule

// ===== rtl/tcwt_table.sv =====
// Connection table: one row per connection, both peers side by side.
// Synchronous memory, one write and one registered read port. Uses tcwt_pkg.
module tcwt_table
    import tcwt_pkg::*;
#(
    parameter int DEPTH = CONNECTIONS_DEF,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output tcwt_row_t     rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  tcwt_row_t     wr_data
);

    tcwt_row_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/tcwt_engine.sv =====
// Segment decision logic: takes one item and its table row, returns the
// updated row and the result. Purely combinational. Uses tcwt_pkg.
module tcwt_engine
    import tcwt_pkg::*;
(
    input  tcwt_item_t   item,
    input  tcwt_row_t    row_in,
    input  tcwt_cfg_t    cfg,
    output tcwt_row_t    row_out,
    output tcwt_result_t result
);

    function automatic logic [3:0] clamp_ws(input logic [7:0] raw, input logic [3:0] lim);
        begin
            return (raw > {4'd0, lim}) ? lim : raw[3:0];
        end
    endfunction

    function automatic void run(
        input  tcwt_item_t   it,
        input  tcwt_row_t    ri,
        input  tcwt_cfg_t    c,
        output tcwt_row_t    ro,
        output tcwt_result_t rs
    );
        tcwt_peer_t  ps;
        tcwt_peer_t  pd;
        logic [7:0]  f;
        logic [3:0]  sws;
        logic [3:0]  dws;
        logic [31:0] endv;
        logic [15:0] win;
        logic [31:0] ack;
        logic [31:0] span;
        logic [31:0] lim;
        logic [31:0] diff;
        logic signed [48:0] skew;
        logic signed [48:0] skew_hi;
        logic [31:0] wsh;
        logic [31:0] cur;
        logic        chk;
        logic        strict;
        logic        loose;
        logic        done;
        logic [31:0] to;
        logic [2:0]  vd;
        logic        rf;
        begin
            f = it.seg_flags;
            ps = '0;
            pd = '0;
            sws = '0;
            dws = '0;
            endv = '0;
            win = it.window;
            ack = it.ack_number;
            span = '0;
            lim = '0;
            diff = '0;
            skew = '0;
            skew_hi = '0;
            wsh = '0;
            cur = '0;
            chk = 1'b1;
            strict = 1'b0;
            loose = 1'b0;
            done = 1'b0;
            to = '0;
            vd = VD_INVALID;
            rf = 1'b0;
            ro = ri;

            case (it.opcode)
                OP_CHECK:
                begin
                    if (!flags_bad(f) && !(f[FB_SYN] && f[FB_ACK]))
                        vd = VD_ACCEPTED;
                end
                OP_CREATE:
                begin
                    ps.seq_cur = it.seq_number;
                    ps.seq_lim = it.seq_number + {16'd0, it.payload_len} + 32'd1;
                    if (f[FB_SYN])
                    begin
                        ps.seq_lim = ps.seq_lim + 32'd1;
                        if (it.wscale_present)
                        begin
                            ps.wshift = clamp_ws(it.wscale_value, c.max_ws);
                            ps.marks[OB_WS] = 1'b1;
                        end
                        if (it.sack_present)
                            ps.marks[OB_SACK] = 1'b1;
                    end
                    else
                    begin
                        ps.wshift = c.max_ws;
                        pd.wshift = c.max_ws;
                        ps.marks[OB_WS] = 1'b1;
                        pd.marks[OB_WS] = 1'b1;
                    end
                    ps.max_win = (it.window != 16'd0) ? it.window : 16'd1;
                    if (ps.wshift != 4'd0)
                        ps.max_win = ceil_shift(ps.max_win, ps.wshift);
                    if (f[FB_FIN])
                        ps.seq_lim = ps.seq_lim + 32'd1;
                    pd.seq_lim = 32'd1;
                    pd.max_win = 16'd1;
                    ps.phase = PH_SYN_SENT;
                    pd.phase = PH_CLOSED;
                    ro.p0 = ps;
                    ro.p1 = pd;
                    vd = VD_ACCEPTED;
                    rf = 1'b1;
                    to = c.to_syn_sent;
                end
                OP_UPDATE:
                begin
                    ps = it.direction ? ri.p1 : ri.p0;
                    pd = it.direction ? ri.p0 : ri.p1;
                    if (flags_bad(f))
                        done = 1'b1;
                    if (!done && f[FB_SYN] && !f[FB_ACK])
                    begin
                        if (pd.phase >= PH_FINWAIT2 && ps.phase >= PH_FINWAIT2)
                        begin
                            ps.phase = PH_CLOSED;
                            pd.phase = PH_CLOSED;
                            vd = VD_REOPEN;
                            done = 1'b1;
                        end
                        else if (ps.phase <= PH_SYN_SENT)
                        begin
                            ps.phase = PH_SYN_SENT;
                            vd = VD_RESTART;
                            rf = 1'b1;
                            to = c.to_syn_sent;
                            done = 1'b1;
                        end
                    end
                    if (!done)
                    begin
                        if (ps.marks[OB_WS] && pd.marks[OB_WS] && !f[FB_SYN])
                        begin
                            sws = ps.wshift;
                            dws = pd.wshift;
                        end
                        endv = it.seq_number + {16'd0, it.payload_len};
                        if (f[FB_SYN])
                            endv = endv + 32'd1;
                        if (ps.phase < PH_SYN_SENT)
                        begin
                            if (f[FB_SYN] && pd.marks[OB_WS])
                            begin
                                if (it.wscale_present)
                                begin
                                    ps.wshift = clamp_ws(it.wscale_value, c.max_ws);
                                    ps.marks[OB_WS] = 1'b1;
                                end
                                if (it.sack_present)
                                    ps.marks[OB_SACK] = 1'b1;
                                if (ps.marks[OB_WS])
                                begin
                                    sws = ps.wshift;
                                    win = ceil_shift(win, sws);
                                    dws = pd.wshift;
                                end
                                else
                                begin
                                    ps.wshift = 4'd0;
                                    pd.wshift = 4'd0;
                                    pd.marks[OB_WS] = 1'b0;
                                end
                            end
                            if (f[FB_FIN])
                                endv = endv + 32'd1;
                            ps.seq_cur = it.seq_number;
                            ps.phase = PH_SYN_SENT;
                            span = {16'd0, pd.max_win} << dws;
                            lim = endv + ((span != 32'd0) ? span : 32'd1);
                            if (ps.seq_lim == 32'd1 || lim >= ps.seq_lim)
                            begin
                                ps.seq_lim = lim;
                                chk = 1'b0;
                            end
                            if (win > ps.max_win)
                                ps.max_win = win;
                        end
                        else if (f[FB_FIN])
                            endv = endv + 32'd1;

                        if (!f[FB_ACK])
                            ack = pd.seq_cur;
                        else if (ack == 32'd0 && f[FB_RST])
                            ack = pd.seq_cur;

                        if (chk)
                        begin
                            diff = pd.seq_cur - ack;
                            skew = {{17{diff[31]}}, diff};
                        end
                        skew_hi = $signed({17'd0, ACK_SLACK << sws});
                        wsh = {16'd0, win} << sws;
                        cur = ps.seq_cur;
                        span = {16'd0, pd.max_win} << dws;
                        strict = seq_geq(ps.seq_lim, endv)
                            && seq_geq(it.seq_number, cur - span)
                            && (skew >= -$signed({17'd0, ACK_SLACK}))
                            && (skew <= skew_hi)
                            && (!f[FB_RST] || it.seq_number == cur
                                || it.seq_number == cur + 32'd1
                                || it.seq_number + 32'd1 == cur);
                        loose = !strict
                            && (pd.phase < PH_SYN_SENT || pd.phase >= PH_FINWAIT2
                                || ps.phase >= PH_FINWAIT2)
                            && seq_geq(ps.seq_lim + ACK_SLACK, endv)
                            && seq_geq(it.seq_number, cur - ACK_SLACK);

                        if (strict || loose)
                        begin
                            if (ps.max_win < win)
                                ps.max_win = win;
                            if (endv != ps.seq_cur && seq_geq(endv, ps.seq_cur))
                                ps.seq_cur = endv;
                            if (seq_geq(ack + wsh, pd.seq_lim))
                                pd.seq_lim = ack + ((wsh != 32'd0) ? wsh : 32'd1);
                            if (strict && f[FB_SYN] && ps.phase < PH_SYN_SENT)
                                ps.phase = PH_SYN_SENT;
                            if (f[FB_FIN] && ps.phase < PH_CLOSING)
                                ps.phase = PH_CLOSING;
                            if (strict && f[FB_ACK])
                            begin
                                if (pd.phase == PH_SYN_SENT)
                                    pd.phase = PH_ESTAB;
                                else if (pd.phase == PH_CLOSING)
                                    pd.phase = PH_FINWAIT2;
                            end
                            if (f[FB_RST])
                            begin
                                ps.phase = PH_TIMEWAIT;
                                pd.phase = PH_TIMEWAIT;
                            end
                            vd = VD_VALID;
                            if (strict)
                            begin
                                rf = 1'b1;
                                if (ps.phase >= PH_FINWAIT2 && pd.phase >= PH_FINWAIT2)
                                    to = c.to_close;
                                else if (ps.phase >= PH_CLOSING && pd.phase >= PH_CLOSING)
                                    to = c.to_fin_wait;
                                else if (ps.phase < PH_ESTAB || pd.phase < PH_ESTAB)
                                    to = c.to_syn_recv;
                                else if (ps.phase >= PH_CLOSING || pd.phase >= PH_CLOSING)
                                    to = c.to_close;
                                else
                                    to = c.to_estab;
                            end
                        end
                    end
                    ro.p0 = it.direction ? pd : ps;
                    ro.p1 = it.direction ? ps : pd;
                end
                default:
                begin
                    vd = VD_INVALID;
                end
            endcase

            rs.verdict = vd;
            rs.refresh = rf;
            rs.expiry = rf ? (it.now_time + to) : 32'd0;
        end
    endfunction

    always_comb
    begin
        run(item, row_in, cfg, row_out, result);
    end

endmodule

// ===== rtl/tcwt_checker.sv =====
// Port-level checks for the TCP window tracker, bound to the top level.
// Uses only the top level's ports.
module tcwt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // One segment at a time: no accept right after an accept.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("back-to-back segment transactions");

    // Verdict codes stop at accepted.
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= 3'd4)
        else $error("verdict out of range");

    // No deadline without a refresh.
    a_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
        else $error("deadline without refresh");

endmodule

bind tcp_conntrack_window_tracker tcwt_checker u_tcwt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== dv/tb_tcp_conntrack_window_tracker.sv =====
// Self-checking testbench for tcp_conntrack_window_tracker: random and directed segments,
// a cycle-accurate-free predictor of verdict, timer refresh and expiry deadline.
// Depends on tcwt_pkg and the RTL of the tracker.
module tb_tcp_conntrack_window_tracker
    import tcwt_pkg::*;
();

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int         LIMIT_CYCLES = 400000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         POOL_MAX = 16;

    localparam logic [7:0] FL_FIN = 8'h01 << FB_FIN;
    localparam logic [7:0] FL_SYN = 8'h01 << FB_SYN;
    localparam logic [7:0] FL_RST = 8'h01 << FB_RST;
    localparam logic [7:0] FL_PSH = 8'h01 << FB_PSH;
    localparam logic [7:0] FL_ACK = 8'h01 << FB_ACK;
    localparam logic [7:0] FL_URG = 8'h01 << FB_URG;

    typedef struct {
        logic [1:0]  op;
        logic [9:0]  conn;
        logic        dir;
        logic [7:0]  flags;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] win;
        logic [15:0] plen;
        logic        ws_present;
        logic [7:0]  ws_value;
        logic        sack_present;
        logic [31:0] now;
    } segment_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    tcp_conntrack_window_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the connection table: two peer slots per connection.
    logic [31:0] peer_seq [2048];
    logic [31:0] peer_lim [2048];
    logic [15:0] peer_mwin [2048];
    logic [3:0]  peer_shift [2048];
    logic [1:0]  peer_marks [2048];
    logic [2:0]  peer_phase [2048];

    // Predictor copy of the registers.
    logic [31:0] tmo_syn_sent;
    logic [31:0] tmo_syn_recv;
    logic [31:0] tmo_estab;
    logic [31:0] tmo_fin_wait;
    logic [31:0] tmo_close;
    logic [3:0]  scale_limit;

    logic [161:0]   segment_q [$];   // {opcode, tdata} waiting to be offered
    tcwt_result_t   verdict_q [$];   // expected results, oldest first
    int             conn_pool [$];   // connections created so far
    int             mismatches = 0;
    int             cycles = 0;
    bit             quiet;
    bit             hold_req;
    bit             hold_seen;
    int             src_gap;
    int             sink_gap;
    int             hold_left;

    // Clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // --- predictor -----------------------------------------------------

    // Flag combinations the tracker refuses outright.
    function automatic bit flags_illegal(logic [7:0] f);
        bit bad;
        bad = 1'b0;
        if (f[FB_SYN])
        begin
            if (f[FB_RST] || f[FB_FIN])
                bad = 1'b1;
        end
        else if (!f[FB_ACK] && !f[FB_RST])
            bad = 1'b1;
        if (!f[FB_ACK] && (f[FB_FIN] || f[FB_PSH] || f[FB_URG]))
            bad = 1'b1;
        return bad;
    endfunction

    function automatic bit wrap_geq(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return !d[31];
    endfunction

    function automatic logic [15:0] scale_up(logic [31:0] v, logic [3:0] sh);
        logic [31:0] t;
        t = (v + (32'd1 << sh) - 32'd1) >> sh;
        return t[15:0];
    endfunction

    // Record window scale and SACK options of a segment on peer slot p.
    function automatic void latch_options(int p, segment_t g);
        if (g.ws_present)
        begin
            peer_shift[p] = ({24'd0, g.ws_value} > {28'd0, scale_limit}) ?
                            scale_limit : g.ws_value[3:0];
            peer_marks[p][OB_WS] = 1'b1;
        end
        if (g.sack_present)
            peer_marks[p][OB_SACK] = 1'b1;
    endfunction

    function automatic tcwt_result_t verdict_only(logic [2:0] v);
        tcwt_result_t r;
        r.verdict = v;
        r.refresh = 1'b0;
        r.expiry = '0;
        return r;
    endfunction

    function automatic tcwt_result_t with_deadline(logic [2:0] v, logic [31:0] now,
                                                   logic [31:0] tmo);
        tcwt_result_t r;
        r.verdict = v;
        r.refresh = 1'b1;
        r.expiry = now + tmo;
        return r;
    endfunction

    // Work out the result of one segment and advance the table copy.
    function automatic tcwt_result_t track_segment(segment_t g);
        int          s;
        int          d;
        logic [7:0]  f;
        logic [31:0] win;
        logic [31:0] ack;
        logic [31:0] seg_end;
        logic [3:0]  sws;
        logic [3:0]  dws;
        logic [31:0] span;
        logic [31:0] lim;
        logic [31:0] diff;
        logic [31:0] wsh;
        logic [31:0] cur;
        longint      skew;
        bit          check_skew;
        bit          strict;
        bit          loose;
        logic [2:0]  ps;
        logic [2:0]  pd;
        logic [31:0] tmo;

        f = g.flags;
        win = {16'd0, g.win};
        ack = g.ack;
        check_skew = 1'b1;
        sws = '0;
        dws = '0;

        if (g.op == OP_CHECK)
            return verdict_only((!flags_illegal(f) && !(f[FB_SYN] && f[FB_ACK])) ?
                                VD_ACCEPTED : VD_INVALID);

        if (g.op == OP_CREATE)
        begin
            s = g.conn * 2;
            d = s + 1;
            peer_marks[s] = '0;
            peer_marks[d] = '0;
            peer_shift[s] = '0;
            peer_shift[d] = '0;
            peer_seq[s] = g.seq;
            peer_seq[d] = '0;
            peer_lim[s] = g.seq + g.plen + 32'd1;
            if (f[FB_SYN])
            begin
                peer_lim[s] = peer_lim[s] + 32'd1;
                latch_options(s, g);
            end
            else
            begin
                peer_shift[s] = scale_limit;
                peer_shift[d] = scale_limit;
                peer_marks[s][OB_WS] = 1'b1;
                peer_marks[d][OB_WS] = 1'b1;
            end
            peer_mwin[s] = (g.win != 0) ? g.win : 16'd1;
            if (peer_shift[s] != 0)
                peer_mwin[s] = scale_up({16'd0, peer_mwin[s]}, peer_shift[s]);
            if (f[FB_FIN])
                peer_lim[s] = peer_lim[s] + 32'd1;
            peer_lim[d] = 32'd1;
            peer_mwin[d] = 16'd1;
            peer_phase[s] = PH_SYN_SENT;
            peer_phase[d] = PH_CLOSED;
            return with_deadline(VD_ACCEPTED, g.now, tmo_syn_sent);
        end

        if (g.op != OP_UPDATE)
            return verdict_only(VD_INVALID);

        s = g.conn * 2 + g.dir;
        d = g.conn * 2 + (g.dir ^ 1'b1);

        if (flags_illegal(f))
            return verdict_only(VD_INVALID);

        // Bare SYN: reopen a finished connection, or restart a handshake.
        if (f[FB_SYN] && !f[FB_ACK])
        begin
            if (peer_phase[d] >= PH_FINWAIT2 && peer_phase[s] >= PH_FINWAIT2)
            begin
                peer_phase[s] = PH_CLOSED;
                peer_phase[d] = PH_CLOSED;
                return verdict_only(VD_REOPEN);
            end
            else if (peer_phase[s] <= PH_SYN_SENT)
            begin
                peer_phase[s] = PH_SYN_SENT;
                return with_deadline(VD_RESTART, g.now, tmo_syn_sent);
            end
        end

        if (peer_marks[s][OB_WS] && peer_marks[d][OB_WS] && !f[FB_SYN])
        begin
            sws = peer_shift[s];
            dws = peer_shift[d];
        end

        seg_end = g.seq + g.plen;
        if (f[FB_SYN])
            seg_end = seg_end + 32'd1;

        // First segment from a closed peer opens its window.
        if (peer_phase[s] < PH_SYN_SENT)
        begin
            if (f[FB_SYN] && peer_marks[d][OB_WS])
            begin
                latch_options(s, g);
                if (peer_marks[s][OB_WS])
                begin
                    sws = peer_shift[s];
                    win = {16'd0, scale_up(win, sws)};
                    dws = peer_shift[d];
                end
                else
                begin
                    peer_shift[s] = '0;
                    peer_shift[d] = '0;
                    peer_marks[d][OB_WS] = 1'b0;
                end
            end
            if (f[FB_FIN])
                seg_end = seg_end + 32'd1;
            peer_seq[s] = g.seq;
            peer_phase[s] = PH_SYN_SENT;
            span = {16'd0, peer_mwin[d]} << dws;
            lim = seg_end + ((span != 0) ? span : 32'd1);
            if (peer_lim[s] == 32'd1 || lim >= peer_lim[s])
            begin
                peer_lim[s] = lim;
                check_skew = 1'b0;
            end
            if (win > {16'd0, peer_mwin[s]})
                peer_mwin[s] = win[15:0];
        end
        else if (f[FB_FIN])
            seg_end = seg_end + 32'd1;

        if (!f[FB_ACK])
            ack = peer_seq[d];
        else if (ack == 0 && f[FB_RST])
            ack = peer_seq[d];

        skew = 0;
        if (check_skew)
        begin
            diff = peer_seq[d] - ack;
            skew = longint'(signed'(diff));
        end

        wsh = win << sws;
        cur = peer_seq[s];
        strict = wrap_geq(peer_lim[s], seg_end)
              && wrap_geq(g.seq, cur - ({16'd0, peer_mwin[d]} << dws))
              && skew >= -longint'(ACK_SLACK)
              && skew <= longint'(ACK_SLACK) * (longint'(1) << sws)
              && (!f[FB_RST] || g.seq == cur || g.seq == cur + 32'd1
                  || g.seq + 32'd1 == cur);
        loose = !strict
             && (peer_phase[d] < PH_SYN_SENT || peer_phase[d] >= PH_FINWAIT2
                 || peer_phase[s] >= PH_FINWAIT2)
             && wrap_geq(peer_lim[s] + ACK_SLACK, seg_end)
             && wrap_geq(g.seq, cur - ACK_SLACK);

        if (!strict && !loose)
            return verdict_only(VD_INVALID);

        if ({16'd0, peer_mwin[s]} < win)
            peer_mwin[s] = win[15:0];
        if (seg_end != peer_seq[s] && wrap_geq(seg_end, peer_seq[s]))
            peer_seq[s] = seg_end;
        if (wrap_geq(ack + wsh, peer_lim[d]))
            peer_lim[d] = ack + ((wsh != 0) ? wsh : 32'd1);

        if (strict && f[FB_SYN] && peer_phase[s] < PH_SYN_SENT)
            peer_phase[s] = PH_SYN_SENT;
        if (f[FB_FIN] && peer_phase[s] < PH_CLOSING)
            peer_phase[s] = PH_CLOSING;
        if (strict && f[FB_ACK])
        begin
            if (peer_phase[d] == PH_SYN_SENT)
                peer_phase[d] = PH_ESTAB;
            else if (peer_phase[d] == PH_CLOSING)
                peer_phase[d] = PH_FINWAIT2;
        end
        if (f[FB_RST])
        begin
            peer_phase[s] = PH_TIMEWAIT;
            peer_phase[d] = PH_TIMEWAIT;
        end
        if (loose)
            return verdict_only(VD_VALID);

        // Pick the timeout from the pair of peer phases.
        ps = peer_phase[s];
        pd = peer_phase[d];
        if (ps >= PH_FINWAIT2 && pd >= PH_FINWAIT2)
            tmo = tmo_close;
        else if (ps >= PH_CLOSING && pd >= PH_CLOSING)
            tmo = tmo_fin_wait;
        else if (ps < PH_ESTAB || pd < PH_ESTAB)
            tmo = tmo_syn_recv;
        else if (ps >= PH_CLOSING || pd >= PH_CLOSING)
            tmo = tmo_close;
        else
            tmo = tmo_estab;
        return with_deadline(VD_VALID, g.now, tmo);
    endfunction

    // --- stimulus ------------------------------------------------------

    // Predict a segment, then queue it for the driver and its result for the checker.
    task automatic post(segment_t g);
        logic [159:0] data;
        data = {3'd0, g.now, g.sack_present, g.ws_value, g.ws_present, g.plen, g.win,
                g.ack, g.seq, g.flags, g.dir, g.conn};
        verdict_q.push_back(track_segment(g));
        segment_q.push_back({g.op, data});
    endtask

    function automatic segment_t blank_segment(logic [1:0] op, int conn);
        segment_t g;
        g.op = op;
        g.conn = conn[9:0];
        g.dir = 1'b0;
        g.flags = FL_ACK;
        g.seq = $urandom;
        g.ack = $urandom;
        g.win = 16'($urandom);
        g.plen = 16'($urandom_range(0, 1500));
        g.ws_present = 1'($urandom_range(0, 1));
        g.ws_value = 8'($urandom);
        g.sack_present = 1'($urandom_range(0, 1));
        g.now = $urandom;
        return g;
    endfunction

    task automatic open_conn(int conn, logic [7:0] flags);
        segment_t g;
        g = blank_segment(OP_CREATE, conn);
        g.flags = flags;
        post(g);
        foreach (conn_pool[i])
            if (conn_pool[i] == conn)
                return;
        if (conn_pool.size() < POOL_MAX)
            conn_pool.push_back(conn);
        else
            conn_pool[$urandom_range(0, POOL_MAX - 1)] = conn;
    endtask

    // In-window segment on an existing connection, built from the tracked sequence state.
    task automatic send_in_window(int conn, logic dir, logic [7:0] flags, int plen);
        segment_t g;
        int       s;
        s = conn * 2 + dir;
        g = blank_segment(OP_UPDATE, conn);
        g.dir = dir;
        g.flags = flags;
        g.seq = peer_seq[s];
        g.ack = peer_seq[s ^ 1];
        g.plen = 16'(plen);
        post(g);
    endtask

    // Mostly well-formed traffic with random content, some noise and broken segments.
    task automatic random_traffic(int count);
        segment_t    g;
        int          sel;
        int          conn;
        int          s;
        logic [7:0]  pick [8];
        pick = '{FL_SYN, FL_SYN | FL_ACK, FL_ACK, FL_ACK | FL_PSH, FL_FIN | FL_ACK,
                 FL_RST, FL_RST | FL_ACK, FL_ACK | FL_URG};
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8 || conn_pool.size() == 0)
                open_conn($urandom_range(0, 1023),
                          ($urandom_range(0, 3) == 0) ? 8'($urandom) : FL_SYN);
            else if (sel < 14)
            begin
                g = blank_segment(($urandom_range(0, 2) == 0) ? OP_UNUSED : OP_CHECK,
                                  $urandom_range(0, 1023));
                g.dir = 1'($urandom_range(0, 1));
                g.flags = 8'($urandom);
                post(g);
            end
            else
            begin
                conn = conn_pool[$urandom_range(0, conn_pool.size() - 1)];
                g = blank_segment(OP_UPDATE, conn);
                g.dir = 1'($urandom_range(0, 1));
                s = conn * 2 + g.dir;
                g.flags = ($urandom_range(0, 6) == 0) ? 8'($urandom)
                                                      : pick[$urandom_range(0, 7)];
                if ($urandom_range(0, 9) < 8)
                    g.seq = peer_seq[s] + 32'($urandom_range(0, 2)) - 32'd1;
                if ($urandom_range(0, 9) < 8)
                    g.ack = peer_seq[s ^ 1] + 32'($urandom_range(0, 2)) - 32'd1;
                if ($urandom_range(0, 15) == 0)
                    g.plen = 16'($urandom);
                post(g);
            end
        end
    endtask

    // Hold off until every queued segment is accepted and every result checked.
    task automatic drain();
        while (segment_q.size() != 0 || verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_SYN_SENT: tmo_syn_sent = value;
            CFG_SYN_RECV: tmo_syn_recv = value;
            CFG_ESTAB:    tmo_estab = value;
            CFG_FIN_WAIT: tmo_fin_wait = value;
            CFG_CLOSE:    tmo_close = value;
            CFG_MAX_WS:   scale_limit = value[3:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] t0, logic [31:0] t1, logic [31:0] t2,
                             logic [31:0] t3, logic [31:0] t4, logic [3:0] ws);
        write_reg(CFG_SYN_SENT, t0);
        write_reg(CFG_SYN_RECV, t1);
        write_reg(CFG_ESTAB, t2);
        write_reg(CFG_FIN_WAIT, t3);
        write_reg(CFG_CLOSE, t4);
        write_reg(CFG_MAX_WS, {28'd0, ws});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Directed handshake, data, close and reopen, plus the odd cases.
    task automatic directed_part();
        segment_t g;
        g = blank_segment(OP_CREATE, 0);
        g.flags = FL_SYN;
        g.ws_present = 1'b1;
        g.ws_value = 8'hff;           // clamp to the scale limit
        g.sack_present = 1'b1;
        g.win = 16'hffff;
        post(g);
        conn_pool.push_back(0);
        send_in_window(0, 1'b1, FL_SYN | FL_ACK, 0);
        send_in_window(0, 1'b0, FL_ACK, 0);
        send_in_window(0, 1'b0, FL_ACK | FL_PSH, 16'hffff);
        send_in_window(0, 1'b1, FL_ACK | FL_URG, 1000);
        send_in_window(0, 1'b0, FL_FIN | FL_ACK, 0);
        send_in_window(0, 1'b1, FL_ACK, 0);
        send_in_window(0, 1'b1, FL_FIN | FL_ACK, 0);
        send_in_window(0, 1'b0, FL_ACK, 0);
        send_in_window(0, 1'b0, FL_SYN, 0);          // reopen finished connection
        send_in_window(0, 1'b0, FL_SYN, 0);          // restarted SYN
        open_conn(1023, FL_ACK | FL_FIN);            // mid-stream pickup, max scale
        send_in_window(1023, 1'b1, FL_ACK, 0);
        send_in_window(1023, 1'b1, FL_RST, 0);
        send_in_window(1023, 1'b0, FL_SYN | FL_FIN, 0);  // illegal flags
        g = blank_segment(OP_CHECK, 5);
        g.flags = FL_SYN;
        post(g);
        g.flags = FL_SYN | FL_ACK;
        post(g);
        g.flags = 8'hff;
        post(g);
        g.flags = 8'h00;
        g.seq = '1;
        g.ack = '0;
        g.now = '1;
        post(g);
        g = blank_segment(OP_UNUSED, 1023);
        g.dir = 1'b1;
        post(g);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet = 1'b0;
        hold_req = 1'b0;
        tmo_syn_sent = 32'd120;
        tmo_syn_recv = 32'd60;
        tmo_estab = 32'd86400;
        tmo_fin_wait = 32'd120;
        tmo_close = 32'd10;
        scale_limit = 4'd14;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults first, with a long receiver hold-off to back up the block.
        directed_part();
        hold_req = 1'b1;
        random_traffic(220);
        drain();

        // Largest timeouts and no window scaling.
        write_all('1, '1, '1, '1, '1, 4'd0);
        random_traffic(220);
        drain();

        // Zero timeouts and the largest scale limit.
        write_all('0, '0, '0, '0, '0, 4'd14);
        directed_part();
        random_traffic(200);
        drain();

        // Random settings, no idling on either side.
        write_all($urandom, $urandom, $urandom, $urandom, $urandom,
                  4'($urandom_range(1, 13)));
        quiet = 1'b1;
        random_traffic(220);
        drain();
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // --- driver: offer queued segments, with random idle bursts ---------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            src_gap <= 0;
        end
        else
        begin : drive
            bit holding;
            if (s_tvalid && s_tready)
                void'(segment_q.pop_front());
            holding = s_tvalid && !s_tready;
            if (holding)
                ;  // keep the current transaction on the bus
            else if (src_gap > 0)
            begin
                src_gap <= src_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (segment_q.size() == 0)
                s_tvalid <= 1'b0;
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                src_gap <= $urandom_range(0, 9);
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tvalid <= 1'b1;
                {s_tuser, s_tdata} <= segment_q[0];
            end
        end
    end

    // --- long receiver hold-off, counted once on request ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else if (hold_req && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // --- monitor: check each result, drive back-pressure ---------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            sink_gap <= 0;
        end
        else
        begin : watch
            tcwt_result_t want;
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: verdict %0d refresh %0d expiry %0h",
                                 m_tuser, m_tdata[0], m_tdata[32:1]);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_tuser !== want.verdict || m_tdata[0] !== want.refresh
                        || m_tdata[32:1] !== want.expiry)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected verdict %0d refresh %0d",
                                     want.verdict, want.refresh,
                                     " expiry %0h,", want.expiry,
                                     " got verdict %0d refresh %0d expiry %0h",
                                     m_tuser, m_tdata[0], m_tdata[32:1]);
                    end
                end
            end

            if (hold_left > 0)
                m_tready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap <= sink_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                sink_gap <= $urandom_range(0, 9);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
